// ===== design/pup_pkg.sv =====
// ----------------------------------------------------------------------------
// pup_pkg
// Types, codes and fixed-point helpers for the particle update pipeline.
// ----------------------------------------------------------------------------
package pup_pkg;

    // particle kinds as carried in s_axis_tuser
    typedef enum logic [2:0] {
        KIND_STATIC   = 3'd0,
        KIND_FIRE     = 3'd1,
        KIND_EXPLODE  = 3'd2,
        KIND_EXPLODE2 = 3'd3,
        KIND_BLOB     = 3'd4,
        KIND_BLOB2    = 3'd5,
        KIND_SLOWGRAV = 3'd6,
        KIND_GRAV     = 3'd7
    } kind_t;

    // per-axis velocity operation
    typedef enum logic [1:0] {
        VOP_NONE = 2'd0,
        VOP_ADD  = 2'd1,
        VOP_SUB  = 2'd2
    } vop_t;

    // which colour ramp a kind uses
    typedef enum logic [1:0] {
        RAMP_NONE  = 2'd0,
        RAMP_FIRE  = 2'd1,
        RAMP_EXPL  = 2'd2,
        RAMP_EXPL2 = 2'd3
    } ramp_sel_t;

    // configuration register indexes
    localparam logic [2:0] CFG_FRAME_STEP      = 3'd0;
    localparam logic [2:0] CFG_CURRENT_TIME    = 3'd1;
    localparam logic [2:0] CFG_FIRE_COLORS     = 3'd2;
    localparam logic [2:0] CFG_EXPLODE_COLORS  = 3'd3;
    localparam logic [2:0] CFG_EXPLODE2_COLORS = 3'd4;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 64;

    localparam logic [5:0]  GRAV_MUL   = 6'd40;
    localparam logic [3:0]  FIRE_STEP  = 4'd5;
    localparam logic [3:0]  EXPL_STEP  = 4'd10;
    localparam logic [3:0]  EXPL2_STEP = 4'd15;
    localparam logic [15:0] FIRE_LIMIT = 16'd24576;
    localparam logic [15:0] EXPL_LIMIT = 16'd32768;

    // decoded per-kind control, travels with the item
    typedef struct packed {
        vop_t      op_x;
        vop_t      op_y;
        vop_t      op_z;
        vop_t      op_grav;
        logic      use_dvel;
        ramp_sel_t ramp_sel;
    } ctl_t;

    function automatic ctl_t decode_kind(input kind_t kind);
        ctl_t c;
        c = '{op_x: VOP_NONE, op_y: VOP_NONE, op_z: VOP_NONE, op_grav: VOP_NONE,
              use_dvel: 1'b0, ramp_sel: RAMP_NONE};
        case (kind)
            KIND_FIRE: begin
                c.op_grav  = VOP_ADD;
                c.ramp_sel = RAMP_FIRE;
            end
            KIND_EXPLODE: begin
                c.op_x = VOP_ADD; c.op_y = VOP_ADD; c.op_z = VOP_ADD;
                c.use_dvel = 1'b1;
                c.op_grav  = VOP_SUB;
                c.ramp_sel = RAMP_EXPL;
            end
            KIND_EXPLODE2: begin
                c.op_x = VOP_SUB; c.op_y = VOP_SUB; c.op_z = VOP_SUB;
                c.op_grav  = VOP_SUB;
                c.ramp_sel = RAMP_EXPL2;
            end
            KIND_BLOB: begin
                c.op_x = VOP_ADD; c.op_y = VOP_ADD; c.op_z = VOP_ADD;
                c.use_dvel = 1'b1;
                c.op_grav  = VOP_SUB;
            end
            KIND_BLOB2: begin
                c.op_x = VOP_SUB; c.op_y = VOP_SUB;
                c.use_dvel = 1'b1;
                c.op_grav  = VOP_SUB;
            end
            KIND_SLOWGRAV, KIND_GRAV: begin
                c.op_grav = VOP_SUB;
            end
            default: begin
            end
        endcase
        return c;
    endfunction

    // clamp a 36-bit signed sum into signed 32 bits
    function automatic logic signed [31:0] sat36(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v[35:31] == 5'b00000 || v[35:31] == 5'b11111) begin
            r = v[31:0];
        end else if (v[35]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7fff_ffff;
        end
        return r;
    endfunction

endpackage

// ===== design/particle_physics_update_unit.sv =====
// ----------------------------------------------------------------------------
// particle_physics_update_unit
// Four-stage pipeline that advances one particle per clock unless stalled.
// ----------------------------------------------------------------------------
// Takes one particle per cycle and passes it through the stage 0 to stage 3
// registers; the sustained rate is one particle per clock while the output is
// not stalled. The four stages are input capture with the expiry check, the six
// velocity multipliers (32 x 17 and 32 x 19 bits) with the ramp advance, the
// floor shift and saturating adds with the ramp colour lookup, and the gravity
// add with the output register. A stall on the result side holds the whole
// pipeline; s_axis_tready follows m_axis_tready when the output register is
// full. Configuration must only be written while no particle is in flight.
module particle_physics_update_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [pup_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pup_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, ramp, expiry, color
    input  logic [247:0]                    s_axis_tdata,
    // kind
    input  logic [2:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z,
    // new_ramp, new_expiry, new_color
    output logic [247:0]                    m_axis_tdata,
    // keep
    output logic                            m_axis_tuser
);
    import pup_pkg::*;

    // configuration
    logic [15:0] frame_step_reg;
    logic [31:0] current_time_reg;
    logic [47:0] fire_colors_reg;
    logic [63:0] explode_colors_reg;
    logic [63:0] explode2_colors_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_step_reg      <= '0;
            current_time_reg    <= '0;
            fire_colors_reg     <= '0;
            explode_colors_reg  <= '0;
            explode2_colors_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_FRAME_STEP:      frame_step_reg      <= cfg_data[15:0];
                CFG_CURRENT_TIME:    current_time_reg    <= cfg_data[31:0];
                CFG_FIRE_COLORS:     fire_colors_reg     <= cfg_data[47:0];
                CFG_EXPLODE_COLORS:  explode_colors_reg  <= cfg_data;
                CFG_EXPLODE2_COLORS: explode2_colors_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    logic [21:0] grav;
    logic [17:0] dvel;
    logic [31:0] kill_time;
    assign grav      = 22'(frame_step_reg * GRAV_MUL);
    assign dvel      = {frame_step_reg, 2'b00};
    assign kill_time = current_time_reg - 32'd1;

    // whole pipeline moves together
    logic en;
    logic s0_valid_reg, s1_valid_reg, s2_valid_reg, s3_valid_reg;
    assign en            = !s3_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else if (en) begin
            s0_valid_reg <= s_axis_tvalid;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // stage 0: capture and expiry check
    logic signed [31:0] s0_pos_reg [3];
    logic signed [31:0] s0_vel_reg [3];
    logic [15:0]        s0_ramp_reg;
    logic [31:0]        s0_expiry_reg;
    logic [7:0]         s0_color_reg;
    ctl_t               s0_ctl_reg;
    logic               s0_keep_reg;
    logic [31:0]        in_age;

    assign in_age = s_axis_tdata[239:208] - current_time_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                s0_pos_reg[i] <= s_axis_tdata[32*i +: 32];
                s0_vel_reg[i] <= s_axis_tdata[96 + 32*i +: 32];
            end
            s0_ramp_reg   <= s_axis_tdata[207:192];
            s0_expiry_reg <= s_axis_tdata[239:208];
            s0_color_reg  <= s_axis_tdata[247:240];
            s0_ctl_reg    <= decode_kind(kind_t'(s_axis_tuser));
            s0_keep_reg   <= !in_age[31];
        end
    end

    // stage 1: products and ramp advance
    logic signed [48:0] s1_pprod_reg [3];
    logic signed [50:0] s1_vprod_reg [3];
    logic signed [31:0] s1_pos_reg   [3];
    logic signed [31:0] s1_vel_reg   [3];
    logic [15:0]        s1_ramp_reg;
    logic [31:0]        s1_expiry_reg;
    logic [7:0]         s1_color_reg;
    ctl_t               s1_ctl_reg;
    logic               s1_keep_reg;

    logic signed [16:0] f_s;
    logic signed [18:0] vmul_s;
    logic [3:0]         ramp_k;
    logic [19:0]        ramp_kf;
    logic [16:0]        ramp_sum;
    logic [15:0]        ramp_adv;

    assign f_s    = $signed({1'b0, frame_step_reg});
    assign vmul_s = s0_ctl_reg.use_dvel ? $signed({1'b0, dvel})
                                        : $signed({3'b000, frame_step_reg});

    always_comb begin
        case (s0_ctl_reg.ramp_sel)
            RAMP_FIRE:  ramp_k = FIRE_STEP;
            RAMP_EXPL:  ramp_k = EXPL_STEP;
            RAMP_EXPL2: ramp_k = EXPL2_STEP;
            default:    ramp_k = 4'd0;
        endcase
        ramp_kf  = frame_step_reg * ramp_k;
        ramp_sum = {1'b0, s0_ramp_reg} + {1'b0, ramp_kf[19:4]};
        ramp_adv = ramp_sum[16] ? 16'hffff : ramp_sum[15:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                s1_pprod_reg[i] <= s0_vel_reg[i] * f_s;
                s1_vprod_reg[i] <= s0_vel_reg[i] * vmul_s;
                s1_pos_reg[i]   <= s0_pos_reg[i];
                s1_vel_reg[i]   <= s0_vel_reg[i];
            end
            s1_ramp_reg   <= (s0_ctl_reg.ramp_sel == RAMP_NONE) ? s0_ramp_reg : ramp_adv;
            s1_expiry_reg <= s0_expiry_reg;
            s1_color_reg  <= s0_color_reg;
            s1_ctl_reg    <= s0_ctl_reg;
            s1_keep_reg   <= s0_keep_reg;
        end
    end

    // stage 2: floor shift, saturating adds, colour lookup
    logic signed [31:0] s2_pos_reg [3];
    logic signed [31:0] s2_vel_reg [3];
    logic [15:0]        s2_ramp_reg;
    logic [31:0]        s2_expiry_reg;
    logic [7:0]         s2_color_reg;
    vop_t               s2_op_grav_reg;
    logic               s2_keep_reg;

    logic signed [31:0] pos_n [3];
    logic signed [31:0] vel_n [3];
    logic [31:0]        expiry_n;
    logic [7:0]         color_n;
    vop_t               vop [3];

    assign vop[0] = s1_ctl_reg.op_x;
    assign vop[1] = s1_ctl_reg.op_y;
    assign vop[2] = s1_ctl_reg.op_z;

    always_comb begin
        logic signed [32:0] pscaled;
        logic signed [34:0] vscaled;
        logic [63:0]        table_sel;
        logic [15:0]        limit;
        logic [2:0]         idx;
        for (int i = 0; i < 3; i++) begin
            // arithmetic shift rounds toward minus infinity
            pscaled  = s1_pprod_reg[i][48:16];
            vscaled  = s1_vprod_reg[i][50:16];
            pos_n[i] = sat36(36'(s1_pos_reg[i]) + 36'(pscaled));
            case (vop[i])
                VOP_ADD: vel_n[i] = sat36(36'(s1_vel_reg[i]) + 36'(vscaled));
                VOP_SUB: vel_n[i] = sat36(36'(s1_vel_reg[i]) - 36'(vscaled));
                default: vel_n[i] = s1_vel_reg[i];
            endcase
        end
        case (s1_ctl_reg.ramp_sel)
            RAMP_FIRE:  table_sel = {16'h0000, fire_colors_reg};
            RAMP_EXPL:  table_sel = explode_colors_reg;
            RAMP_EXPL2: table_sel = explode2_colors_reg;
            default:    table_sel = '0;
        endcase
        limit    = (s1_ctl_reg.ramp_sel == RAMP_FIRE) ? FIRE_LIMIT : EXPL_LIMIT;
        idx      = s1_ramp_reg[14:12];
        expiry_n = s1_expiry_reg;
        color_n  = s1_color_reg;
        if (s1_ctl_reg.ramp_sel != RAMP_NONE) begin
            if (s1_ramp_reg >= limit) begin
                expiry_n = kill_time;
            end else begin
                color_n = table_sel[{idx, 3'b000} +: 8];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                s2_pos_reg[i] <= pos_n[i];
                s2_vel_reg[i] <= vel_n[i];
            end
            s2_ramp_reg    <= s1_ramp_reg;
            s2_expiry_reg  <= expiry_n;
            s2_color_reg   <= color_n;
            s2_op_grav_reg <= s1_ctl_reg.op_grav;
            s2_keep_reg    <= s1_keep_reg;
        end
    end

    // stage 3: gravity and output register
    logic [247:0]       s3_data_reg;
    logic               s3_keep_reg;
    logic signed [31:0] velz_n;
    logic [247:0]       data_n;

    always_comb begin
        case (s2_op_grav_reg)
            VOP_ADD: velz_n = sat36(36'(s2_vel_reg[2]) + 36'(grav));
            VOP_SUB: velz_n = sat36(36'(s2_vel_reg[2]) - 36'(grav));
            default: velz_n = s2_vel_reg[2];
        endcase
        data_n = {s2_color_reg, s2_expiry_reg, s2_ramp_reg, velz_n, s2_vel_reg[1],
                  s2_vel_reg[0], s2_pos_reg[2], s2_pos_reg[1], s2_pos_reg[0]};
        // expired particles carry all-zero fields
        if (!s2_keep_reg) begin
            data_n = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_data_reg <= data_n;
            s3_keep_reg <= s2_keep_reg;
        end
    end

    assign m_axis_tvalid = s3_valid_reg;
    assign m_axis_tdata  = s3_data_reg;
    assign m_axis_tuser  = s3_keep_reg;

endmodule

// ===== design/pup_checker.sv =====
// ----------------------------------------------------------------------------
// pup_checker
// Port-level checks for the particle update pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module pup_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [247:0] m_axis_tdata,
    input logic         m_axis_tuser
);

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // stalled result transaction stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // stalled result payload holds
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // a full stalled output blocks new input
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while output stalled");

    // dropped particles carry zero fields
    a_drop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("dropped particle with nonzero fields");

endmodule

bind particle_physics_update_unit pup_checker u_pup_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
